### design/ctr_pkg.sv
// ---------------------------------------------------------------------------
// ctr_pkg: shared types and constants for the cache tag replacement model
// Holds the defaults, register indexes, state encoding, the channel
// payloads and the controller/datapath command and status structs.
// ---------------------------------------------------------------------------
package ctr_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int ADDR_WIDTH_DEF  = 32;
   localparam int NUM_WAYS_DEF    = 4;
   localparam int TAG_W           = 32;
   localparam int STAMP_W         = 32;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 4;

   localparam logic [CSR_IDX_W-1:0] REG_ASSOC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POLICY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY  = 2'd3;

   localparam logic [1:0] MODE_SET  = 2'd1;
   localparam logic [1:0] MODE_FULL = 2'd2;
   localparam logic [1:0] POL_FIFO  = 2'd0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HIT,
      ST_FREE,
      ST_AGE,
      ST_WRITE,
      ST_RESP
   } state_type;

   // request beat payload
   typedef struct packed {
      logic [ADDR_WIDTH_DEF-1:0] address;
   } req_type;

   // response beat payload
   typedef struct packed {
      logic             evicted;
      logic [TAG_W-1:0] victim_tag;
   } rsp_type;

   // command from controller to datapath
   typedef struct packed {
      logic clear_step;   // clear one valid bit at the clear sweep pointer
      logic load;         // capture address and decode group
      logic scan_start;   // reset scan pointer to group base
      logic scan_step;    // issue next read / evaluate
      logic do_write;     // write chosen entry
      logic rsp_load;     // load result register
   } cmd_type;

   // status back to controller
   typedef struct packed {
      logic clear_done;
      logic scan_done;    // group scan finished: no read issued or pending
      logic hit;          // valid entry with matching tag seen
      logic free_found;   // invalid entry seen
      logic victim_ok;    // oldest entry picked
      logic lru;          // lru policy: stamp refreshed on a hit
   } stat_type;

endpackage

### design/ctr_if.sv
// ---------------------------------------------------------------------------
// ctr_stream_if: valid/ready channel
// Generic payload of one beat, with source and sink modports.
// ---------------------------------------------------------------------------
interface ctr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### design/ctr_ram.sv
// ---------------------------------------------------------------------------
// ctr_ram: generic single port ram
// One address per cycle, read and optionally written, registered read data.
// ---------------------------------------------------------------------------
module ctr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### design/ctr_datapath.sv
// ---------------------------------------------------------------------------
// ctr_datapath: address decode, tag/stamp/valid stores and group scan
// Scans one entry of the selected group per cycle through the rams.
// ---------------------------------------------------------------------------
module ctr_datapath #(
   parameter int MAX_ENTRIES = ctr_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_WIDTH  = ctr_pkg::ADDR_WIDTH_DEF,
   parameter int NUM_WAYS    = ctr_pkg::NUM_WAYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctr_pkg::cmd_type      cmd,
   input  ctr_pkg::state_type    state,
   output ctr_pkg::stat_type     stat,
   input  logic [ADDR_WIDTH-1:0] req_address,
   input  logic [1:0]            cfg_assoc,
   input  logic [1:0]            cfg_policy,
   input  logic [3:0]            cfg_offset,
   input  logic [3:0]            cfg_entry,
   output logic                  rsp_evicted,
   output logic [ctr_pkg::TAG_W-1:0] rsp_victim_tag
);
   import ctr_pkg::*;

   localparam int IW   = $clog2(MAX_ENTRIES);
   localparam int CW   = IW + 1;
   localparam int MAXB = $clog2(MAX_ENTRIES + 1) - 1;
   localparam int WB   = $clog2(NUM_WAYS + 1) - 1;

   // decoded group
   logic [CW-1:0]        base_ff, base_in, count_ff, count_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [CW-1:0]        ptr_ff, ptr_in;     // address issued
   logic [CW-1:0]        eval_ff, eval_in;   // entry whose data is arriving
   logic                 eval_v_ff, eval_v_in;
   logic                 lru_ff;
   logic                 hit_ff, free_ff, have_ff;
   logic [IW-1:0]        pick_ff;
   logic [STAMP_W-1:0]   best_ff, best_ff_in;
   logic [TAG_W-1:0]     vtag_ff;
   logic [STAMP_W-1:0]   counter_ff;
   logic [IW:0]          clr_ff;
   logic                 ev_ff;
   logic [TAG_W-1:0]     vt_ff;

   // decode
   logic [3:0]            off, eb;
   logic [ADDR_WIDTH-1:0] block;
   logic [CW-1:0]         entries;
   always_comb begin
      off = (cfg_offset > 4'd12) ? 4'd12 : cfg_offset;
      eb  = (cfg_entry < 4'd2) ? 4'd2 : cfg_entry;
      if (eb > 4'(MAXB)) eb = 4'(MAXB);
      block   = req_address >> off;
      entries = CW'(1) << eb;
      base_in  = base_ff;
      count_in = count_ff;
      tag_in   = tag_ff;
      if (cmd.load) begin
         if (cfg_assoc == MODE_SET) begin
            if (eb > 4'(WB)) begin
               base_in  = CW'((block & ((ADDR_WIDTH'(1) << (eb - 4'(WB))) - 1'b1))
                              << WB);
               count_in = CW'(1) << WB;
               tag_in   = TAG_W'(block >> (eb - 4'(WB)));
            end else begin
               base_in  = '0;
               count_in = entries;
               tag_in   = TAG_W'(block);
            end
         end else if (cfg_assoc == MODE_FULL) begin
            base_in  = '0;
            count_in = entries;
            tag_in   = TAG_W'(block);
         end else begin
            base_in  = CW'(block & ADDR_WIDTH'(entries - 1'b1));
            count_in = CW'(1);
            tag_in   = TAG_W'(block >> eb);
         end
      end
   end

   // rams, the valid store is cleared by the sweep after reset
   logic [IW-1:0]      ram_addr;
   logic               ram_we;
   logic [TAG_W-1:0]   tag_rd;
   logic [STAMP_W-1:0] stamp_rd;
   logic               tag_we;
   logic               valid_we;
   logic               valid_wd;
   logic               valid_rd;
   logic [IW-1:0]      wr_idx;
   always_comb begin
      wr_idx   = pick_ff;
      ram_we   = cmd.do_write;
      tag_we   = cmd.do_write && !hit_ff;
      valid_we = cmd.clear_step || tag_we;
      valid_wd = !cmd.clear_step;
      if (cmd.clear_step) begin
         ram_addr = clr_ff[IW-1:0];
      end else if (cmd.do_write) begin
         ram_addr = wr_idx;
      end else begin
         ram_addr = ptr_ff[IW-1:0];
      end
   end

   ctr_ram #(.WIDTH(TAG_W), .DEPTH(MAX_ENTRIES)) u_tag (
      .clock(clock), .wr_en(tag_we), .addr(ram_addr),
      .wr_data(tag_ff), .rd_data(tag_rd));
   ctr_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_ENTRIES)) u_stamp (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(counter_ff), .rd_data(stamp_rd));
   ctr_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_valid (
      .clock(clock), .wr_en(valid_we), .addr(ram_addr),
      .wr_data(valid_wd), .rd_data(valid_rd));

   // scan pointers
   logic          issue;
   logic [IW-1:0] eidx;
   logic          ev_valid;
   always_comb begin
      issue     = cmd.scan_step && (ptr_ff < base_ff + count_ff)
                  && (ptr_ff < CW'(MAX_ENTRIES));
      if (cmd.load) begin
         ptr_in = base_in;
      end else if (cmd.scan_start) begin
         ptr_in = base_ff;
      end else begin
         ptr_in = issue ? ptr_ff + 1'b1 : ptr_ff;
      end
      eval_v_in = issue;
      eval_in   = ptr_ff;
      eidx      = eval_ff[IW-1:0];
      ev_valid  = valid_rd;
      best_ff_in = best_ff;
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      count_ff <= count_in;
      tag_ff   <= tag_in;
      ptr_ff   <= ptr_in;
      eval_ff  <= eval_in;
      if (cmd.load) lru_ff <= (cfg_policy != POL_FIFO);
   end

   // evaluation of one returned entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_v_ff <= 1'b0;
      end else begin
         eval_v_ff <= eval_v_in && !cmd.scan_start;
      end
      if (cmd.scan_start || cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         have_ff <= 1'b0;
      end else if (eval_v_ff) begin
         unique case (state)
            ST_HIT: begin
               if (!hit_ff && ev_valid && tag_rd == tag_ff) begin
                  hit_ff  <= 1'b1;
                  pick_ff <= eidx;
               end
            end
            ST_FREE: begin
               if (!free_ff && !ev_valid) begin
                  free_ff <= 1'b1;
                  pick_ff <= eidx;
               end
            end
            ST_AGE: begin
               if (!have_ff || stamp_rd < best_ff) begin
                  have_ff <= 1'b1;
                  pick_ff <= eidx;
                  best_ff <= stamp_rd;
                  vtag_ff <= tag_rd;
               end
            end
            default: begin
               best_ff <= best_ff_in;
            end
         endcase
      end
   end

   // clear sweep and access counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         counter_ff <= '0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.rsp_load && counter_ff != '1) counter_ff <= counter_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         ev_ff <= !hit_ff && !free_ff && have_ff;
         vt_ff <= (!hit_ff && !free_ff && have_ff) ? vtag_ff : '0;
      end
   end

   assign rsp_evicted    = ev_ff;
   assign rsp_victim_tag = vt_ff;

   always_comb begin
      stat.clear_done = (clr_ff == (IW+1)'(MAX_ENTRIES - 1)) && cmd.clear_step;
      stat.scan_done  = !issue && !eval_v_ff;
      stat.hit        = hit_ff;
      stat.free_found = free_ff;
      stat.victim_ok  = have_ff;
      stat.lru        = lru_ff;
   end
endmodule

### design/ctr_control.sv
// ---------------------------------------------------------------------------
// ctr_control: sequencer for clear, hit scan, free scan, age scan, write, result
// Issues datapath commands and drives the channel handshakes.
// ---------------------------------------------------------------------------
module ctr_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               rsp_fire,
   input  ctr_pkg::stat_type  stat,
   output ctr_pkg::cmd_type   cmd,
   output ctr_pkg::state_type state,
   output logic               req_ready_o,
   output logic               rsp_valid_o
);
   import ctr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_v_ff, rsp_v_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_fire) state_in = ST_HIT;
         ST_HIT:   if (stat.scan_done) state_in = stat.hit ? ST_WRITE : ST_FREE;
         ST_FREE:  if (stat.scan_done) state_in = stat.free_found ? ST_WRITE : ST_AGE;
         ST_AGE:   if (stat.scan_done) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_RESP;
         ST_RESP:  if (!rsp_v_ff || rsp_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE:  begin
            cmd.load = req_fire;
         end
         ST_HIT:   begin
            cmd.scan_step  = 1'b1;
            cmd.scan_start = stat.scan_done && !stat.hit;
         end
         ST_FREE:  begin
            cmd.scan_step  = 1'b1;
            cmd.scan_start = stat.scan_done && !stat.free_found;
         end
         ST_AGE:   cmd.scan_step = 1'b1;
         // a hit refreshes the stamp only under lru
         ST_WRITE: cmd.do_write = stat.hit ? stat.lru : (stat.free_found || stat.victim_ok);
         ST_RESP:  cmd.rsp_load = !rsp_v_ff || rsp_fire;
         default:  cmd = '0;
      endcase
   end

   always_comb begin
      rsp_v_in = rsp_v_ff;
      if (rsp_fire) rsp_v_in = 1'b0;
      if (cmd.rsp_load) rsp_v_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   assign state       = state_ff;
   assign req_ready_o = (state_ff == ST_IDLE);
   assign rsp_valid_o = rsp_v_ff;
endmodule

### design/cache_tag_replacement_sim.sv
// ---------------------------------------------------------------------------
// cache_tag_replacement_sim: tag store with fifo / lru replacement
// Takes byte addresses, reports evictions and victim tags.
// ---------------------------------------------------------------------------
// One address is handled at a time. Its group of N entries (1 in direct
// mapped mode, NUM_WAYS in set associative mode, all 2^entry_bits in fully
// associative mode) is scanned through the single port tag, stamp and valid
// memories one entry per cycle, in passes: a hit pass, then on a
// miss a free way pass, then if the group is full an oldest stamp pass.
// The accept comes before the passes, the write and result steps follow.
// After reset the valid bits are cleared by a sweep over all MAX_ENTRIES
// entries before the first address is taken. The result register lets
// the next address enter while a result waits; that address then holds
// in its result cycle until the waiting beat is taken.
module cache_tag_replacement_sim #(
   parameter int MAX_ENTRIES = ctr_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_WIDTH  = ctr_pkg::ADDR_WIDTH_DEF,
   parameter int NUM_WAYS    = ctr_pkg::NUM_WAYS_DEF
) (
   input  logic clock,
   input  logic reset,
   ctr_stream_if.sink   req,
   ctr_stream_if.source rsp,
   input  logic                            csr_we,
   input  logic [ctr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ctr_pkg::CSR_DATA_W-1:0] csr_data
);
   import ctr_pkg::*;

   logic [1:0] assoc_ff, policy_ff;
   logic [3:0] offset_ff, entry_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         assoc_ff  <= 2'd0;
         policy_ff <= 2'd0;
         offset_ff <= 4'd4;
         entry_ff  <= 4'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ASSOC:  assoc_ff  <= csr_data[1:0];
            REG_POLICY: policy_ff <= csr_data[1:0];
            REG_OFFSET: offset_ff <= csr_data;
            REG_ENTRY:  entry_ff  <= csr_data;
            default:    assoc_ff  <= assoc_ff;
         endcase
      end
   end

   cmd_type   cmd;
   stat_type  stat;
   state_type state;
   logic      req_fire, rsp_fire;
   logic      evicted;
   logic [TAG_W-1:0] victim;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   ctr_datapath #(
      .MAX_ENTRIES(MAX_ENTRIES), .ADDR_WIDTH(ADDR_WIDTH), .NUM_WAYS(NUM_WAYS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .state(state), .stat(stat),
      .req_address(ADDR_WIDTH'(req.data.address)),
      .cfg_assoc(assoc_ff), .cfg_policy(policy_ff),
      .cfg_offset(offset_ff), .cfg_entry(entry_ff),
      .rsp_evicted(evicted), .rsp_victim_tag(victim)
   );

   ctr_control u_ctl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .stat(stat), .cmd(cmd), .state(state),
      .req_ready_o(req.ready), .rsp_valid_o(rsp.valid)
   );

   assign rsp.data.evicted    = evicted;
   assign rsp.data.victim_tag = victim;

`ifndef SYNTHESIS
   // no input taken while a group is being scanned
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   // a stalled result holds its victim tag
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(rsp.data.victim_tag))
      else $error("result changed under stall");
   // no victim tag without an eviction
   a_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.data.evicted) |-> (rsp.data.victim_tag == '0))
      else $error("victim tag without eviction");
`endif
endmodule
